// File: rtl/core/rvgc_pkg.sv
// Package for the vertical grid line ray caster.
// Widths, codes, controller command/status structs, state types, CORDIC angle table.
// No dependencies.
`default_nettype none
package rvgc_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int POS_W        = 22;
	localparam int ANG_W        = 16;
	localparam int DIST_W       = 32;
	localparam int STAT_W       = 2;
	localparam int CELL_W       = 6;
	localparam int DIM_W        = 7;
	localparam int NUDGE_W      = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int MAP_COLS_DEF = 64;
	localparam int MAP_ROWS_DEF = 64;

	localparam int CORD_W       = 32;
	localparam int CORDIC_STEPS = 30;
	localparam int CORD_SH_W    = 5;
	localparam int MAG_W        = 14;
	localparam int TRIG_DIV_W   = 29;
	localparam int TRIG_Q_W     = 45;
	localparam int DIV_STEPS    = TRIG_Q_W;
	localparam int TRIG_CNT_W   = 6;
	localparam logic signed [CORD_W-1:0] CORDIC_X0 = 32'sd268435456;
	localparam logic [TRIG_DIV_W-1:0] CORDIC_RG = 29'd442048841;

	localparam int DX_W        = 32;
	localparam int DY_W        = 64;
	localparam int WCOORD_W    = 8;
	localparam int BND_W       = WCOORD_W + 1;
	localparam int MUL_CHUNK_W = 15;
	localparam int MUL_CHUNKS  = 3;
	localparam int MUL_CNT_W   = 2;
	localparam int PROD_W      = DX_W + TRIG_Q_W;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_NUDGE = 2'd2;

	localparam logic OP_WRITE_CELL = 1'b0;
	localparam logic OP_CAST       = 1'b1;

	localparam logic signed [ANG_W-1:0] ANG_QUARTER = 16'sd16384;

	typedef enum logic [STAT_W-1:0] {
		RES_WALL = 2'd0,
		RES_LEFT = 2'd1,
		RES_VERT = 2'd2
	} res_code_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_TRIG,
		ST_RD,
		ST_CHK,
		ST_DY_GO,
		ST_MUL_DY,
		ST_POS,
		ST_MUL_DIST,
		ST_RESULT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		TP_IDLE,
		TP_CORDIC,
		TP_DIVIDE
	} trig_phase_t;

	typedef struct packed {
		logic      clear_step;
		logic      cell_wr;
		logic      cast_load;
		logic      trig_start;
		logic      walk_start;
		logic      map_rd;
		logic      step_first;
		logic      step_adv;
		logic      mul_start;
		logic      mul_dist;
		logic      dy_load;
		logic      pos_upd;
		logic      code_wr;
		res_code_t code;
		logic      res_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic op_cast;
		logic vertical;
		logic trig_busy;
		logic mul_busy;
		logic cell_out;
		logic cell_wall;
		logic step_first;
		logic step_cap;
		logic outside;
	} ctrl_sts_t;

	function automatic logic [CORD_W-1:0] atan_turn(input logic [CORD_SH_W-1:0] i);
		logic [CORD_W-1:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/rvgc_ifs.sv
// Valid/ready channel interfaces for cast requests and cast results.
// Depends on rvgc_pkg for field widths.
`default_nettype none
interface rvgc_in_if;
	logic                            valid;
	logic                            ready;
	logic                            operation;
	logic [rvgc_pkg::CELL_W-1:0]     cell_col;
	logic [rvgc_pkg::CELL_W-1:0]     cell_row;
	logic                            cell_is_wall;
	logic [rvgc_pkg::POS_W-1:0]      pos_x;
	logic [rvgc_pkg::POS_W-1:0]      pos_y;
	logic signed [rvgc_pkg::ANG_W-1:0] angle;

	modport source(output valid, operation, cell_col, cell_row, cell_is_wall, pos_x, pos_y,
		angle, input ready);
	modport sink(input valid, operation, cell_col, cell_row, cell_is_wall, pos_x, pos_y,
		angle, output ready);
endinterface

interface rvgc_out_if;
	logic                          valid;
	logic                          ready;
	logic [rvgc_pkg::DIST_W-1:0]   distance;
	logic [rvgc_pkg::STAT_W-1:0]   status;
	logic [rvgc_pkg::CELL_W-1:0]   hit_col;
	logic [rvgc_pkg::CELL_W-1:0]   hit_row;

	modport source(output valid, distance, status, hit_col, hit_row, input ready);
	modport sink(input valid, distance, status, hit_col, hit_row, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rvgc_trig.sv
// Tangent/secant unit: 30-step iterative CORDIC, then two restoring dividers in step.
// Depends on rvgc_pkg.
`default_nettype none
module rvgc_trig (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rvgc_pkg::MAG_W-1:0]        mag,
	output logic                              busy,
	output logic [rvgc_pkg::TRIG_Q_W-1:0]     tan_val,
	output logic [rvgc_pkg::TRIG_Q_W-1:0]     sec_val
);
	import rvgc_pkg::*;

	trig_phase_t phase_q, phase_d;
	logic [TRIG_CNT_W-1:0] cnt_q;
	logic signed [CORD_W-1:0] x_q, y_q, z_q;
	logic signed [CORD_W-1:0] xs, ys, x_n, y_n, z_n;
	logic [CORD_SH_W-1:0] sh;
	logic [TRIG_DIV_W-1:0] dvs_q, dvs_n;
	logic [TRIG_Q_W-1:0] nt_q, ns_q, qt_q, qs_q, nt_n;
	logic [TRIG_DIV_W-1:0] rt_q, rs_q;
	logic [TRIG_DIV_W:0] rt_sh, rs_sh;
	logic cord_last, div_last;

	assign sh = cnt_q[CORD_SH_W-1:0];
	assign cord_last = (cnt_q == TRIG_CNT_W'(CORDIC_STEPS - 1));
	assign div_last  = (cnt_q == TRIG_CNT_W'(DIV_STEPS - 1));

	// arithmetic shifts round toward zero
	always_comb begin
		xs = x_q[CORD_W-1] ? -((-x_q) >>> sh) : (x_q >>> sh);
		ys = y_q[CORD_W-1] ? -((-y_q) >>> sh) : (y_q >>> sh);
		if (!z_q[CORD_W-1]) begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - $signed(atan_turn(sh));
		end else begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + $signed(atan_turn(sh));
		end
		dvs_n = (x_n < 32'sd1) ? TRIG_DIV_W'(1) : x_n[TRIG_DIV_W-1:0];
		nt_n  = y_n[CORD_W-1] ? '0 : {y_n[TRIG_DIV_W-1:0], {FRAC_BITS{1'b0}}};
		rt_sh = {rt_q, nt_q[TRIG_Q_W-1]};
		rs_sh = {rs_q, ns_q[TRIG_Q_W-1]};
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			TP_IDLE:   if (start) phase_d = TP_CORDIC;
			TP_CORDIC: if (cord_last) phase_d = TP_DIVIDE;
			TP_DIVIDE: if (div_last) phase_d = TP_IDLE;
			default:   phase_d = TP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= TP_IDLE;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (phase_q != phase_d) cnt_q <= '0;
			else if (phase_q != TP_IDLE) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == TP_IDLE && start) begin
			x_q <= CORDIC_X0;
			y_q <= '0;
			z_q <= $signed(CORD_W'(mag) << FRAC_BITS);
		end else if (phase_q == TP_CORDIC) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			if (cord_last) begin
				dvs_q <= dvs_n;
				nt_q  <= nt_n;
				ns_q  <= {CORDIC_RG, {FRAC_BITS{1'b0}}};
				rt_q  <= '0;
				rs_q  <= '0;
				qt_q  <= '0;
				qs_q  <= '0;
			end
		end else if (phase_q == TP_DIVIDE) begin
			nt_q <= nt_q << 1;
			ns_q <= ns_q << 1;
			if (rt_sh >= {1'b0, dvs_q}) begin
				rt_q <= TRIG_DIV_W'(rt_sh - {1'b0, dvs_q});
				qt_q <= {qt_q[TRIG_Q_W-2:0], 1'b1};
			end else begin
				rt_q <= rt_sh[TRIG_DIV_W-1:0];
				qt_q <= {qt_q[TRIG_Q_W-2:0], 1'b0};
			end
			if (rs_sh >= {1'b0, dvs_q}) begin
				rs_q <= TRIG_DIV_W'(rs_sh - {1'b0, dvs_q});
				qs_q <= {qs_q[TRIG_Q_W-2:0], 1'b1};
			end else begin
				rs_q <= rs_sh[TRIG_DIV_W-1:0];
				qs_q <= {qs_q[TRIG_Q_W-2:0], 1'b0};
			end
		end
	end

	assign busy    = (phase_q != TP_IDLE);
	assign tan_val = qt_q;
	assign sec_val = qs_q;
endmodule
`default_nettype wire

// File: rtl/core/rvgc_dp.sv
// Datapath: config registers, wall map, walk registers, chunked multiplier, result register.
// Depends on rvgc_pkg and rvgc_trig.
`default_nettype none
module rvgc_dp #(
	parameter int MAP_COLS = rvgc_pkg::MAP_COLS_DEF,
	parameter int MAP_ROWS = rvgc_pkg::MAP_ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rvgc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rvgc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                operation,
	input  logic [rvgc_pkg::CELL_W-1:0]         cell_col,
	input  logic [rvgc_pkg::CELL_W-1:0]         cell_row,
	input  logic                                cell_is_wall,
	input  logic [rvgc_pkg::POS_W-1:0]          pos_x,
	input  logic [rvgc_pkg::POS_W-1:0]          pos_y,
	input  logic signed [rvgc_pkg::ANG_W-1:0]   angle,
	input  rvgc_pkg::ctrl_cmd_t                 cmd,
	output rvgc_pkg::ctrl_sts_t                 sts,
	output logic [rvgc_pkg::DIST_W-1:0]         distance,
	output logic [rvgc_pkg::STAT_W-1:0]         status,
	output logic [rvgc_pkg::CELL_W-1:0]         hit_col,
	output logic [rvgc_pkg::CELL_W-1:0]         hit_row
);
	import rvgc_pkg::*;

	localparam int MAP_CELLS = MAP_COLS * MAP_ROWS;
	localparam int AW        = $clog2(MAP_CELLS);
	localparam int LIN_W     = 18;
	localparam int STEP_CAP  = 4 * MAP_COLS + 16;
	localparam int K_W       = $clog2(STEP_CAP + 1);

	logic [DIM_W-1:0]   map_width_q, map_height_q;
	logic [NUDGE_W-1:0] edge_nudge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= DIM_W'(64);
			map_height_q <= DIM_W'(64);
			edge_nudge_q <= NUDGE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAP_WIDTH:  map_width_q  <= cfg_data[DIM_W-1:0];
				CFG_MAP_HEIGHT: map_height_q <= cfg_data[DIM_W-1:0];
				CFG_EDGE_NUDGE: edge_nudge_q <= cfg_data[NUDGE_W-1:0];
				default: ;
			endcase
		end
	end

	// cast request
	logic [POS_W-1:0] x_q, y_q;
	logic signed [ANG_W-1:0] angle_q;

	always_ff @(posedge clk) begin
		if (cmd.cast_load) begin
			x_q     <= pos_x;
			y_q     <= pos_y;
			angle_q <= angle;
		end
	end

	logic signed [ANG_W:0] a17, r17;
	logic vertical, right, neg, up;
	logic [MAG_W-1:0] mag;

	always_comb begin
		a17      = {angle_q[ANG_W-1], angle_q};
		vertical = (angle_q == ANG_QUARTER) || (angle_q == -ANG_QUARTER);
		right    = (angle_q > -ANG_QUARTER) && (angle_q < ANG_QUARTER);
		if (right) r17 = a17;
		else if (angle_q > 0) r17 = a17 - 17'sd32768;
		else r17 = a17 + 17'sd32768;
		neg = r17[ANG_W];
		mag = neg ? MAG_W'(-r17) : r17[MAG_W-1:0];
		up  = (right == !neg);
	end

	logic trig_busy;
	logic [TRIG_Q_W-1:0] tan_val, sec_val;

	rvgc_trig u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.trig_start),
		.mag     (mag),
		.busy    (trig_busy),
		.tan_val (tan_val),
		.sec_val (sec_val)
	);

	// wall map with clearing sweep
	logic mem [MAP_CELLS];
	logic [AW:0] clr_q;
	logic [LIN_W-1:0] wr_lin, rd_lin;
	logic wr_ok, rd_q, inb_q, inb;
	logic [WCOORD_W-1:0] col_q, row_q;
	logic [BND_W-1:0] cl, rl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear_step) clr_q <= clr_q + 1'b1;
	end

	always_comb begin
		wr_lin = LIN_W'(cell_row) * LIN_W'(MAP_COLS) + LIN_W'(cell_col);
		rd_lin = LIN_W'(row_q) * LIN_W'(MAP_COLS) + LIN_W'(col_q);
		wr_ok  = (BND_W'(cell_col) < BND_W'(MAP_COLS)) && (BND_W'(cell_row) < BND_W'(MAP_ROWS));
		cl = (BND_W'(map_width_q) < BND_W'(MAP_COLS)) ? BND_W'(map_width_q) : BND_W'(MAP_COLS);
		rl = (BND_W'(map_height_q) < BND_W'(MAP_ROWS)) ? BND_W'(map_height_q) : BND_W'(MAP_ROWS);
		inb = (BND_W'(col_q) < cl) && (BND_W'(row_q) < rl);
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step) mem[clr_q[AW-1:0]] <= 1'b0;
		else if (cmd.cell_wr && wr_ok) mem[wr_lin[AW-1:0]] <= cell_is_wall;
		if (cmd.map_rd) begin
			rd_q  <= mem[rd_lin[AW-1:0]];
			inb_q <= inb;
		end
	end

	// walk
	logic [DX_W-1:0] dx_q;
	logic [DY_W-1:0] dy_q;
	logic [K_W-1:0]  k_q;
	logic [FRAC_BITS-1:0] frac;
	logic [FRAC_BITS+1:0] dx0, one_cell;
	logic [DX_W:0] px_r;
	logic [POS_W-1:0] px_l, py_u;
	logic [DY_W:0] py_d;
	logic out_l, out_u, outside;
	logic [WCOORD_W-1:0] col_n, row_n;
	logic [PROD_W-1:0] acc_q;

	always_comb begin
		frac     = x_q[FRAC_BITS-1:0];
		one_cell = (FRAC_BITS+2)'(1) << FRAC_BITS;
		if (right)
			dx0 = ((frac != '0) ? one_cell - (FRAC_BITS+2)'(frac) : '0) + (FRAC_BITS+2)'(edge_nudge_q);
		else
			dx0 = (FRAC_BITS+2)'(frac) + (FRAC_BITS+2)'(edge_nudge_q);

		px_r  = (DX_W+1)'(x_q) + (DX_W+1)'(dx_q);
		out_l = dx_q > DX_W'(x_q);
		px_l  = x_q - dx_q[POS_W-1:0];
		out_u = dy_q > DY_W'(y_q);
		py_u  = y_q - dy_q[POS_W-1:0];
		py_d  = (DY_W+1)'(y_q) + (DY_W+1)'(dy_q);
		outside = (!right && out_l) || (up && out_u);

		if (right)
			col_n = (|px_r[DX_W:FRAC_BITS+WCOORD_W]) ? '1 : px_r[FRAC_BITS+WCOORD_W-1:FRAC_BITS];
		else
			col_n = WCOORD_W'(px_l[POS_W-1:FRAC_BITS]);
		if (up)
			row_n = WCOORD_W'(py_u[POS_W-1:FRAC_BITS]);
		else
			row_n = (|py_d[DY_W:FRAC_BITS+WCOORD_W]) ? '1 : py_d[FRAC_BITS+WCOORD_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			col_q <= WCOORD_W'(x_q[POS_W-1:FRAC_BITS]);
			row_q <= WCOORD_W'(y_q[POS_W-1:FRAC_BITS]);
			dx_q  <= '0;
			dy_q  <= '0;
			k_q   <= '0;
		end else begin
			if (cmd.step_first) begin
				dx_q <= DX_W'(dx0);
				k_q  <= k_q + 1'b1;
			end else if (cmd.step_adv) begin
				dx_q <= dx_q + DX_W'(one_cell);
				dy_q <= dy_q + DY_W'(tan_val);
				k_q  <= k_q + 1'b1;
			end
			if (cmd.dy_load) dy_q <= DY_W'(acc_q[PROD_W-1:FRAC_BITS]);
			if (cmd.pos_upd) begin
				col_q <= col_n;
				row_q <= row_n;
			end
		end
	end

	// multiplier: one 15-bit slice of the trig operand per cycle
	logic [DX_W-1:0] mul_a_q;
	logic [TRIG_Q_W-1:0] mul_b_q, b_sh;
	logic [MUL_CNT_W-1:0] mcnt_q;
	logic mbusy_q;
	logic [DX_W+MUL_CHUNK_W-1:0] pp;

	always_comb begin
		b_sh = mul_b_q >> (32'(mcnt_q) * MUL_CHUNK_W);
		pp   = mul_a_q * b_sh[MUL_CHUNK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mcnt_q  <= '0;
		end else if (cmd.mul_start) begin
			mbusy_q <= 1'b1;
			mcnt_q  <= '0;
		end else if (mbusy_q) begin
			if (mcnt_q == MUL_CNT_W'(MUL_CHUNKS - 1)) mbusy_q <= 1'b0;
			else mcnt_q <= mcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mul_a_q <= dx_q;
			mul_b_q <= cmd.mul_dist ? sec_val : tan_val;
			acc_q   <= '0;
		end else if (mbusy_q) begin
			acc_q <= acc_q + (PROD_W'(pp) << (32'(mcnt_q) * MUL_CHUNK_W));
		end
	end

	// result
	res_code_t code_q;
	logic [DIST_W-1:0] dist_sat;

	always_ff @(posedge clk) begin
		if (cmd.code_wr) code_q <= cmd.code;
	end

	always_comb begin
		if (code_q == RES_VERT || (|acc_q[PROD_W-1:FRAC_BITS+DIST_W])) dist_sat = '1;
		else dist_sat = acc_q[FRAC_BITS+DIST_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			distance <= dist_sat;
			status   <= code_q;
			hit_col  <= (code_q == RES_WALL) ? col_q[CELL_W-1:0] : '0;
			hit_row  <= (code_q == RES_WALL) ? row_q[CELL_W-1:0] : '0;
		end
	end

	always_comb begin
		sts.clear_done = (clr_q == (AW+1)'(MAP_CELLS));
		sts.op_cast    = (operation == OP_CAST);
		sts.vertical   = vertical;
		sts.trig_busy  = trig_busy;
		sts.mul_busy   = mbusy_q;
		sts.cell_out   = !inb_q;
		sts.cell_wall  = inb_q && rd_q;
		sts.step_first = (k_q == '0);
		sts.step_cap   = (k_q == K_W'(STEP_CAP));
		sts.outside    = outside;
	end
endmodule
`default_nettype wire

// File: rtl/core/rvgc_ctrl.sv
// Controller: map clearing, cast sequencing, walk loop and output register handshake.
// Depends on rvgc_pkg.
`default_nettype none
module rvgc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  rvgc_pkg::ctrl_sts_t  sts,
	output rvgc_pkg::ctrl_cmd_t  cmd
);
	import rvgc_pkg::*;

	ctrl_state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = !sts.clear_done;
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.op_cast) begin
						cmd.cast_load = 1'b1;
						state_d = ST_START;
					end else begin
						cmd.cell_wr = 1'b1;
					end
				end
			end
			ST_START: begin
				if (sts.vertical) begin
					cmd.code_wr = 1'b1;
					cmd.code    = RES_VERT;
					state_d = ST_RESULT;
				end else begin
					cmd.trig_start = 1'b1;
					cmd.walk_start = 1'b1;
					state_d = ST_TRIG;
				end
			end
			ST_TRIG: if (!sts.trig_busy) state_d = ST_RD;
			ST_RD: begin
				cmd.map_rd = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (sts.cell_out || sts.cell_wall || sts.step_cap) begin
					cmd.code_wr   = 1'b1;
					cmd.code      = (!sts.cell_out && sts.cell_wall) ? RES_WALL : RES_LEFT;
					cmd.mul_start = 1'b1;
					cmd.mul_dist  = 1'b1;
					state_d = ST_MUL_DIST;
				end else if (sts.step_first) begin
					cmd.step_first = 1'b1;
					state_d = ST_DY_GO;
				end else begin
					cmd.step_adv = 1'b1;
					state_d = ST_POS;
				end
			end
			ST_DY_GO: begin
				cmd.mul_start = 1'b1;
				state_d = ST_MUL_DY;
			end
			ST_MUL_DY: begin
				if (!sts.mul_busy) begin
					cmd.dy_load = 1'b1;
					state_d = ST_POS;
				end
			end
			ST_POS: begin
				if (sts.outside) begin
					cmd.code_wr   = 1'b1;
					cmd.code      = RES_LEFT;
					cmd.mul_start = 1'b1;
					cmd.mul_dist  = 1'b1;
					state_d = ST_MUL_DIST;
				end else begin
					cmd.pos_upd = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_MUL_DIST: if (!sts.mul_busy) state_d = ST_RESULT;
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("input ready during map clear");
	a_res_into_free_reg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending transfer");
	a_res_shows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> out_valid_q)
		else $error("loaded result not presented");
	a_mul_not_restarted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !sts.mul_busy)
		else $error("multiplier restarted while busy");
`endif
endmodule
`default_nettype wire

// File: rtl/core/ray_vertical_grid_cast_core.sv
// A cast at exactly a quarter turn answers without trig or walk; any other cast first
// computes tangent and secant (a start state, 30 CORDIC iterations and a restoring divide),
// then walks the grid column by column (the first column includes a multiply for the
// vertical travel), then does the distance multiply; one wall map port is read per column.
// After reset the map is cleared one cell a cycle, all MAP_COLS*MAP_ROWS cells (4096 by
// default), before the first item is taken.
// Top level; depends on rvgc_pkg, rvgc_ifs, rvgc_trig, rvgc_dp, rvgc_ctrl.
`default_nettype none
module ray_vertical_grid_cast_core #(
	parameter int MAP_COLS = rvgc_pkg::MAP_COLS_DEF,
	parameter int MAP_ROWS = rvgc_pkg::MAP_ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rvgc_in_if.sink                           in_ch,
	rvgc_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [rvgc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rvgc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rvgc_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;
	logic in_ready, out_valid;

	rvgc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rvgc_dp #(
		.MAP_COLS (MAP_COLS),
		.MAP_ROWS (MAP_ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (in_ch.operation),
		.cell_col     (in_ch.cell_col),
		.cell_row     (in_ch.cell_row),
		.cell_is_wall (in_ch.cell_is_wall),
		.pos_x        (in_ch.pos_x),
		.pos_y        (in_ch.pos_y),
		.angle        (in_ch.angle),
		.cmd          (cmd),
		.sts          (sts),
		.distance     (out_ch.distance),
		.status       (out_ch.status),
		.hit_col      (out_ch.hit_col),
		.hit_row      (out_ch.hit_row)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;
endmodule
`default_nettype wire
